// ===== src/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  // count registers above this limit are used as the limit
  localparam logic [15:0] MAX_DIVISIONS = 16'd1023;
  localparam int TRIG_ITER_DEF = 16;
  localparam int ATAN_LEN = 24;

  // numerator width of the long dividers, one quotient bit per stage
  localparam int DIV_NW = 42;
  localparam int DIV_DW = 11;

  // pipeline stages besides the divider and the CORDIC iterations
  localparam int EXTRA_STAGES = 7;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-k in turns, 2^32 is a full turn
  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // register map, word index
  localparam logic [1:0] REG_STACK_COUNT   = 2'd0;
  localparam logic [1:0] REG_SLICE_COUNT   = 2'd1;
  localparam logic [1:0] REG_SPHERE_RADIUS = 2'd2;

  // quadrant of a phase
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic valid;
    logic err;
  } div_side_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [1:0]  quad_phi;
    logic [1:0]  quad_theta;
  } trig_side_t;

  typedef struct packed {
    logic        valid;
    logic        err;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } tail_side_t;

endpackage

// ===== src/uvs_divider.sv =====
// ----------------------------------------------------------------------------
// uvs_divider
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module uvs_divider import uvs_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] work_r [NW];
  logic [DW-1:0] den_r  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] work_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] work_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = num;
      assign den_in  = den;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign work_in = work_r[k-1];
      assign den_in  = den_r[k-1];
    end

    // numerator bits leave at the top, quotient bits enter at the bottom
    always_comb begin
      trial    = {rem_in, work_in[NW-1]};
      fits     = (trial >= {1'b0, den_in});
      rem_nxt  = fits ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      work_nxt = {work_in[NW-2:0], fits};
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      work_r[k] <= work_nxt;
      den_r[k]  <= den_in;
    end
  end

  assign quo = work_r[NW-1];

endmodule

// ===== src/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Normal, position and texture coordinate of one vertex of a UV sphere.
// ----------------------------------------------------------------------------
// One vertex request is taken every clock cycle (busy stays low). Its result
// is on the out_ ports with out_valid for a single cycle; the receiver must
// take it then. The pipeline is made of the 42-stage bit-per-stage dividers
// that form the angle phases and texture coordinates, followed by one
// pipeline stage per CORDIC iteration, plus seven stages for input capture,
// CORDIC load, quadrant, products, rounding, scaling and the output register.
// The user must write counts and radius through the APB port only while no
// request is in flight; the block itself does not enforce this.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         in_stack_index,
  input  logic [9:0]         in_slice_index,
  output logic               out_valid,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  output logic               out_index_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NW = DIV_NW;
  localparam int T  = TRIG_ITERATIONS;

  // ---------------- configuration ----------------
  logic [9:0]  stack_count_r, slice_count_r;
  logic [15:0] sphere_radius_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r   <= 10'd16;
      slice_count_r   <= 10'd32;
      sphere_radius_r <= 16'd256;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_STACK_COUNT:   stack_count_r   <= pwdata[9:0];
        REG_SLICE_COUNT:   slice_count_r   <= pwdata[9:0];
        REG_SPHERE_RADIUS: sphere_radius_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STACK_COUNT:   prdata = {22'd0, stack_count_r};
      REG_SLICE_COUNT:   prdata = {22'd0, slice_count_r};
      REG_SPHERE_RADIUS: prdata = {16'd0, sphere_radius_r};
      default:           prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  logic       accept;
  logic [9:0] st_eff, sl_eff;
  logic       err_nxt;
  logic       s0_valid_r, s0_err_r;
  logic [9:0] s0_i_r, s0_j_r, s0_st_r, s0_sl_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    st_eff  = ({6'd0, stack_count_r} > MAX_DIVISIONS) ? MAX_DIVISIONS[9:0] : stack_count_r;
    sl_eff  = ({6'd0, slice_count_r} > MAX_DIVISIONS) ? MAX_DIVISIONS[9:0] : slice_count_r;
    err_nxt = (st_eff == '0) || (sl_eff == '0) ||
              (in_stack_index > st_eff) || (in_slice_index > sl_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else        s0_valid_r <= accept;
  end

  always_ff @(posedge clk) begin
    s0_err_r <= err_nxt;
    s0_i_r   <= in_stack_index;
    s0_j_r   <= in_slice_index;
    s0_st_r  <= st_eff;
    s0_sl_r  <= sl_eff;
  end

  // ---------------- dividers ----------------
  logic [NW-1:0] phi_num, th_num, tu_num, tv_num;
  logic [NW-1:0] phi_quo, th_quo, tu_quo, tv_quo;

  always_comb begin
    phi_num = {s0_i_r, 32'd0} + NW'(s0_st_r);
    th_num  = {s0_j_r, 32'd0} + NW'(s0_sl_r >> 1);
    tu_num  = NW'({s0_j_r, 16'd0}) + NW'(s0_sl_r >> 1);
    tv_num  = NW'({s0_i_r, 16'd0}) + NW'(s0_st_r >> 1);
  end

  uvs_divider #(.NW(NW), .DW(DIV_DW)) u_div_phi (
    .clk(clk), .num(phi_num), .den({s0_st_r, 1'b0}), .quo(phi_quo));
  uvs_divider #(.NW(NW), .DW(DIV_DW)) u_div_theta (
    .clk(clk), .num(th_num), .den({1'b0, s0_sl_r}), .quo(th_quo));
  uvs_divider #(.NW(NW), .DW(DIV_DW)) u_div_u (
    .clk(clk), .num(tu_num), .den({1'b0, s0_sl_r}), .quo(tu_quo));
  uvs_divider #(.NW(NW), .DW(DIV_DW)) u_div_v (
    .clk(clk), .num(tv_num), .den({1'b0, s0_st_r}), .quo(tv_quo));

  div_side_t dsd_r [NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) dsd_r[k] <= '0;
    end else begin
      dsd_r[0] <= '{valid: s0_valid_r, err: s0_err_r};
      for (int k = 1; k < NW; k++) dsd_r[k] <= dsd_r[k-1];
    end
  end

  // ---------------- CORDIC ----------------
  logic [31:0] phi_ph, th_ph, phi_sum, th_sum, phi_res, th_res;
  logic [1:0]  phi_q, th_q;

  always_comb begin
    phi_ph  = phi_quo[31:0];
    th_ph   = th_quo[31:0];
    phi_sum = phi_ph + 32'h2000_0000;
    th_sum  = th_ph + 32'h2000_0000;
    phi_q   = phi_sum[31:30];
    th_q    = th_sum[31:30];
    phi_res = phi_ph - {phi_q, 30'd0};
    th_res  = th_ph - {th_q, 30'd0};
  end

  logic signed [33:0] px_r [T+1];
  logic signed [33:0] py_r [T+1];
  logic signed [32:0] pz_r [T+1];
  logic signed [33:0] tx_r [T+1];
  logic signed [33:0] ty_r [T+1];
  logic signed [32:0] tz_r [T+1];
  trig_side_t         csd_r [T+1];

  always_ff @(posedge clk) begin
    px_r[0] <= CORDIC_GAIN;
    py_r[0] <= '0;
    pz_r[0] <= $signed({phi_res[31], phi_res});
    tx_r[0] <= CORDIC_GAIN;
    ty_r[0] <= '0;
    tz_r[0] <= $signed({th_res[31], th_res});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= T; k++) csd_r[k] <= '0;
    end else begin
      csd_r[0] <= '{valid: dsd_r[NW-1].valid, err: dsd_r[NW-1].err,
                    tex_u: tu_quo[16:0], tex_v: tv_quo[16:0],
                    quad_phi: phi_q, quad_theta: th_q};
      for (int k = 1; k <= T; k++) csd_r[k] <= csd_r[k-1];
    end
  end

  for (genvar k = 0; k < T; k++) begin : g_cordic
    logic signed [32:0] atan_k;
    assign atan_k = $signed({1'b0, ATAN_TURNS[k]});

    always_ff @(posedge clk) begin
      if (!pz_r[k][32]) begin
        px_r[k+1] <= px_r[k] - (py_r[k] >>> k);
        py_r[k+1] <= py_r[k] + (px_r[k] >>> k);
        pz_r[k+1] <= pz_r[k] - atan_k;
      end else begin
        px_r[k+1] <= px_r[k] + (py_r[k] >>> k);
        py_r[k+1] <= py_r[k] - (px_r[k] >>> k);
        pz_r[k+1] <= pz_r[k] + atan_k;
      end
      if (!tz_r[k][32]) begin
        tx_r[k+1] <= tx_r[k] - (ty_r[k] >>> k);
        ty_r[k+1] <= ty_r[k] + (tx_r[k] >>> k);
        tz_r[k+1] <= tz_r[k] - atan_k;
      end else begin
        tx_r[k+1] <= tx_r[k] + (ty_r[k] >>> k);
        ty_r[k+1] <= ty_r[k] - (tx_r[k] >>> k);
        tz_r[k+1] <= tz_r[k] + atan_k;
      end
    end
  end

  // ---------------- quadrant, products, scaling ----------------
  function automatic logic [63:0] quad_rot(input logic [1:0] q,
                                           input logic signed [33:0] x,
                                           input logic signed [33:0] y);
    logic signed [33:0] c, s;
    case (q)
      QUAD_0:  begin c = x;  s = y;  end
      QUAD_1:  begin c = -y; s = x;  end
      QUAD_2:  begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    return {c[31:0], s[31:0]};
  endfunction

  function automatic logic signed [15:0] clamp_norm(input logic signed [31:0] v);
    logic signed [32:0] sum;
    logic signed [16:0] sh;
    sum = $signed({v[31], v}) + 33'sd32768;
    sh  = 17'(sum >>> 16);
    if (sh > 17'sd16384)       return 16'sd16384;
    else if (sh < -17'sd16384) return -16'sd16384;
    else                       return sh[15:0];
  endfunction

  function automatic logic signed [16:0] clamp_pos(input logic signed [48:0] p);
    logic signed [48:0] sum;
    logic signed [18:0] sh;
    sum = p + 49'sd536870912;
    sh  = 19'(sum >>> 30);
    if (sh > 19'sd65535)       return 17'sd65535;
    else if (sh < -19'sd65535) return -17'sd65535;
    else                       return sh[16:0];
  endfunction

  tail_side_t         tsd_r [4];
  logic signed [31:0] cp_r, sp_r, ct_r, st_r;
  logic signed [63:0] mx_r, mz_r;
  logic signed [31:0] my_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic signed [48:0] wx_r, wy_r, wz_r;
  logic signed [15:0] nx_r, ny_r, nz_r;
  logic signed [63:0] rx_sum, rz_sum;
  logic signed [16:0] radius_s;

  assign rx_sum   = mx_r + 64'sd536870912;
  assign rz_sum   = mz_r + 64'sd536870912;
  assign radius_s = $signed({1'b0, sphere_radius_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) tsd_r[k] <= '0;
    end else begin
      tsd_r[0] <= '{valid: csd_r[T].valid, err: csd_r[T].err,
                    tex_u: csd_r[T].tex_u, tex_v: csd_r[T].tex_v};
      for (int k = 1; k < 4; k++) tsd_r[k] <= tsd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    {cp_r, sp_r} <= quad_rot(csd_r[T].quad_phi, px_r[T], py_r[T]);
    {ct_r, st_r} <= quad_rot(csd_r[T].quad_theta, tx_r[T], ty_r[T]);
    mx_r <= sp_r * ct_r;
    mz_r <= sp_r * st_r;
    my_r <= cp_r;
    vx_r <= 32'(rx_sum >>> 30);
    vz_r <= 32'(rz_sum >>> 30);
    vy_r <= my_r;
    wx_r <= vx_r * radius_s;
    wy_r <= vy_r * radius_s;
    wz_r <= vz_r * radius_s;
    nx_r <= clamp_norm(vx_r);
    ny_r <= clamp_norm(vy_r);
    nz_r <= clamp_norm(vz_r);
  end

  // ---------------- output register ----------------
  logic ok;
  assign ok = !tsd_r[3].err;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= tsd_r[3].valid;
  end

  always_ff @(posedge clk) begin
    out_pos_x       <= ok ? clamp_pos(wx_r) : '0;
    out_pos_y       <= ok ? clamp_pos(wy_r) : '0;
    out_pos_z       <= ok ? clamp_pos(wz_r) : '0;
    out_norm_x      <= ok ? nx_r : '0;
    out_norm_y      <= ok ? ny_r : '0;
    out_norm_z      <= ok ? nz_r : '0;
    out_tex_u       <= ok ? tsd_r[3].tex_u : '0;
    out_tex_v       <= ok ? tsd_r[3].tex_v : '0;
    out_index_error <= tsd_r[3].err;
  end

endmodule

// ===== src/uvs_checker.sv =====
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
module uvs_checker import uvs_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [16:0] out_pos_x,
  input logic signed [15:0] out_norm_x,
  input logic signed [15:0] out_norm_y,
  input logic signed [15:0] out_norm_z,
  input logic [16:0]        out_tex_u,
  input logic [16:0]        out_tex_v,
  input logic               out_index_error
);

  localparam int LAT = DIV_NW + TRIG_ITERATIONS + EXTRA_STAGES;

  // every result comes from a transaction accepted a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_error) |->
      (out_pos_x == 0 && out_norm_x == 0 && out_norm_y == 0 &&
       out_norm_z == 0 && out_tex_u == 0 && out_tex_v == 0))
    else $error("index error result not zeroed");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_u <= 17'd65536 && out_tex_v <= 17'd65536 &&
                   out_norm_y <= 16'sd16384 && out_norm_y >= -16'sd16384))
    else $error("result field out of range");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind uv_sphere_vertex_generator uvs_checker #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_uvs_checker (.*);
